[rtl/core/ookpwd_pkg.sv]
// Shared types and constants for the OOK pulse-width code decoder.
`timescale 1ns / 1ps

package ookpwd_pkg;

  localparam int PW_W     = 16;
  localparam int REG_W    = 15;
  localparam int CODE_W   = 11;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Packet framing.
  localparam int PACKET_PULSES = 26;
  localparam int SKIP_PULSES   = 3;
  localparam int CODE_BITS     = 11;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic [REG_W-1:0] UNIT_LENGTH_RESET = 15'd330;
  localparam logic [REG_W-1:0] TOLERANCE_RESET   = 15'd115;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COUNT = 2'd1,
    STATUS_BAD_WIDTH = 2'd2,
    STATUS_ZERO_CODE = 2'd3
  } status_t;

  typedef struct packed {
    logic [PW_W-1:0] pulse_width;
    logic            last_pulse;
  } in_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] status;
  } out_req_t;

  // Window hits for one high pulse.
  typedef struct packed {
    logic in_short;
    logic in_long;
  } win_t;

endpackage

[rtl/core/ookpwd_window.sv]
// Window compare of one pulse width against the short and long nominal widths.
`timescale 1ns / 1ps

module ookpwd_window
  import ookpwd_pkg::*;
(
  input  logic [PW_W-1:0]  pulse_width,
  input  logic [REG_W-1:0] unit_length,
  input  logic [REG_W-1:0] tolerance,
  output win_t             win
);

  localparam int SUM_W = REG_W + 2;

  logic [SUM_W-1:0] width_plus_tol;
  logic [SUM_W-1:0] width_ext;
  logic [SUM_W-1:0] unit1;
  logic [SUM_W-1:0] unit2;
  logic [SUM_W-1:0] tol_ext;
  logic [SUM_W-1:0] hi1;
  logic [SUM_W-1:0] hi2;

  // The lower bound is tested as width + tol >= center, so a negative bound never wraps.
  always_comb begin
    width_ext      = {1'b0, pulse_width};
    tol_ext        = {2'b00, tolerance};
    unit1          = {2'b00, unit_length};
    unit2          = {1'b0, unit_length, 1'b0};
    width_plus_tol = width_ext + tol_ext;
    hi1            = unit1 + tol_ext;
    hi2            = unit2 + tol_ext;
    win.in_short   = (width_plus_tol >= unit1) && (width_ext <= hi1);
    win.in_long    = (width_plus_tol >= unit2) && (width_ext <= hi2);
  end

endmodule

[rtl/core/ook_pulse_width_code_decoder_top.sv]
// Top level of the OOK pulse-width code decoder.
`timescale 1ns / 1ps

//  Channel | Ports                          | Direction | Carries
//  --------+--------------------------------+-----------+---------------------------------
//  input   | in_valid, in_stall, in_data    | in        | one pulse width and last flag
//  result  | out_valid, out_stall, out_data | out       | code and status, one per packet
//  config  | cfg_we, cfg_index, cfg_wdata   | in        | unit_length, tolerance writes
//
// Each request passes an input register and then the result register. One request is
// taken every cycle while in_stall is low. The window compares and the packet state
// update sit between those two registers. Reset is synchronous on rst_n and restores
// the register defaults and an empty packet. A stalled result holds the result register;
// one more request waits in the input register, and in_stall rises only when that
// register is full and cannot drain.

module ook_pulse_width_code_decoder_top
  import ookpwd_pkg::*;
#(
  parameter int PKT_PULSES = PACKET_PULSES,
  parameter int SKIP_CNT   = SKIP_PULSES,
  parameter int DATA_BITS  = CODE_BITS
)
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,

  output logic                 out_valid,
  input  logic                 out_stall,
  output out_req_t             out_data,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int SLOT_END = SKIP_CNT + 2 * DATA_BITS;

  // Configuration registers.
  logic [REG_W-1:0] unit_length_r;
  logic [REG_W-1:0] tolerance_r;

  // Input register.
  logic    s1_valid_r;
  in_req_t s1_data_r;

  // Packet state.
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] code_nxt;
  logic              bad_r;
  logic              bad_nxt;

  // Result register.
  logic     out_valid_r;
  out_req_t out_data_r;
  out_req_t out_data_nxt;

  logic             proc;
  logic             data_slot;
  logic [IDX_W-1:0] rel_idx;
  logic [IDX_W:0]   count;
  win_t             win;
  status_t          status;

  // The stored pulse moves on whenever the result register has room.
  assign proc     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !proc;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ookpwd_window u_window (
    .pulse_width (s1_data_r.pulse_width),
    .unit_length (unit_length_r),
    .tolerance   (tolerance_r),
    .win         (win)
  );

  always_comb begin
    // High pulses of the data pairs sit at even offsets after the preamble.
    rel_idx   = idx_r - IDX_W'(SKIP_CNT);
    data_slot = ({1'b0, idx_r} >= (IDX_W+1)'(SKIP_CNT)) &&
                ({1'b0, idx_r} < (IDX_W+1)'(SLOT_END)) && !rel_idx[0];

    code_nxt = code_r;
    bad_nxt  = bad_r;
    if (data_slot) begin
      if (win.in_short) begin
        code_nxt = {code_r[CODE_W-2:0], 1'b0};
      end else if (win.in_long) begin
        code_nxt = {code_r[CODE_W-2:0], 1'b1};
      end else begin
        bad_nxt = 1'b1;
      end
    end

    idx_nxt = (idx_r != IDX_MAX) ? idx_r + 1'b1 : idx_r;

    // A saturated count reads as 32, which never matches the packet length.
    count = {1'b0, idx_r} + 1'b1;
    if (count != (IDX_W+1)'(PKT_PULSES)) begin
      status = STATUS_BAD_COUNT;
    end else if (bad_nxt) begin
      status = STATUS_BAD_WIDTH;
    end else if (code_nxt == '0) begin
      status = STATUS_ZERO_CODE;
    end else begin
      status = STATUS_OK;
    end

    out_data_nxt.status = status;
    out_data_nxt.code   = (status == STATUS_OK) ? code_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_length_r <= UNIT_LENGTH_RESET;
      tolerance_r   <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_LENGTH: unit_length_r <= cfg_wdata;
        REG_TOLERANCE:   tolerance_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Packet state advances with each processed pulse and clears after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      code_r <= '0;
      bad_r  <= 1'b0;
    end else if (proc) begin
      if (s1_data_r.last_pulse) begin
        idx_r  <= '0;
        code_r <= '0;
        bad_r  <= 1'b0;
      end else begin
        idx_r  <= idx_nxt;
        code_r <= code_nxt;
        bad_r  <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s1_data_r.last_pulse) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_data_r.last_pulse) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An ok result always carries a nonzero code.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == STATUS_OK) |-> out_data_r.code != '0)
    else $error("ok result with zero code");

  // Any error status carries a zero code.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != STATUS_OK) |-> out_data_r.code == '0)
    else $error("error result with nonzero code");

  // Emitting a result starts a fresh packet.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_data_r.last_pulse |=> (idx_r == '0) && (code_r == '0) && !bad_r)
    else $error("packet state not cleared after result");
`endif

endmodule
